@@ design/fpa_pkg.sv @@
`default_nettype none
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int NUM_W = WORD_BITS + FRAC_BITS + 1;
  localparam int SAT_W = 2 * WORD_BITS + 2;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
    OP_GT   = 4'd4,  OP_LT   = 4'd5,  OP_GE   = 4'd6,  OP_LE   = 4'd7,
    OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_MIN  = 4'd10, OP_MAX  = 4'd11,
    OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FROM = 4'd14, OP_TOI  = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic                          valid;
    op_t                           op;
    logic signed [WORD_BITS-1:0]   res;
    logic                          cmp;
    logic [1:0]                    status;
    logic signed [2*WORD_BITS-1:0] prod;
    logic [NUM_W-1:0]              num;
    logic [WORD_BITS-1:0]          den;
    logic [WORD_BITS-1:0]          rem;
    logic [NUM_W-1:0]              quo;
    logic                          neg;
  } tok_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        ovf;
  } sat_t;

  function automatic sat_t saturate(input logic signed [SAT_W-1:0] v);
    sat_t s;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'({1'b0, {(WORD_BITS-1){1'b1}}}));
    lo = -hi - SAT_W'(1);
    s.ovf = 1'b0;
    s.val = v[WORD_BITS-1:0];
    if (v > hi) begin
      s.ovf = 1'b1;
      s.val = hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      s.ovf = 1'b1;
      s.val = lo[WORD_BITS-1:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

@@ design/fpa_front.sv @@
`default_nettype none
module fpa_front (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  en,
  input  wire                                  in_valid,
  input  wire  [3:0]                           opcode,
  input  wire  signed [fpa_pkg::WORD_BITS-1:0] operand_a,
  input  wire  signed [fpa_pkg::WORD_BITS-1:0] operand_b,
  output fpa_pkg::tok_t                        tok
);

  localparam int W = fpa_pkg::WORD_BITS;
  localparam int F = fpa_pkg::FRAC_BITS;
  localparam int S = fpa_pkg::SAT_W;

  fpa_pkg::tok_t  t;
  fpa_pkg::sat_t  s;
  fpa_pkg::op_t   op;
  logic [W-1:0]   mag_a;
  logic signed [W-1:0] bias;

  always_comb begin
    op    = fpa_pkg::op_t'(opcode);
    mag_a = operand_a[W-1] ? W'(-operand_a) : W'(operand_a);
    bias  = operand_a[W-1] ? W'((1 << F) - 1) : '0;
    s     = '0;
    t     = '0;
    t.valid = in_valid;
    t.op    = op;
    t.prod  = operand_a * operand_b;
    t.num   = {mag_a, {(F+1){1'b0}}};
    t.den   = operand_b[W-1] ? W'(-operand_b) : W'(operand_b);
    t.neg   = operand_a[W-1] ^ operand_b[W-1];
    unique case (op)
      fpa_pkg::OP_ADD:  s = fpa_pkg::saturate(S'(operand_a) + S'(operand_b));
      fpa_pkg::OP_SUB:  s = fpa_pkg::saturate(S'(operand_a) - S'(operand_b));
      fpa_pkg::OP_INC:  s = fpa_pkg::saturate(S'(operand_a) + S'(1));
      fpa_pkg::OP_DEC:  s = fpa_pkg::saturate(S'(operand_a) - S'(1));
      fpa_pkg::OP_FROM: s = fpa_pkg::saturate(S'(operand_a) <<< F);
      fpa_pkg::OP_TOI:  s.val = (operand_a + bias) >>> F;
      fpa_pkg::OP_MIN:  s.val = (operand_a > operand_b) ? operand_b : operand_a;
      fpa_pkg::OP_MAX:  s.val = (operand_a > operand_b) ? operand_a : operand_b;
      fpa_pkg::OP_GT:   t.cmp = operand_a > operand_b;
      fpa_pkg::OP_LT:   t.cmp = operand_a < operand_b;
      fpa_pkg::OP_GE:   t.cmp = operand_a >= operand_b;
      fpa_pkg::OP_LE:   t.cmp = operand_a <= operand_b;
      fpa_pkg::OP_EQ:   t.cmp = operand_a == operand_b;
      fpa_pkg::OP_NE:   t.cmp = operand_a != operand_b;
      default: ;
    endcase
    t.res    = s.val;
    t.status = s.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
    if (op == fpa_pkg::OP_DIV && operand_b == '0) begin
      t.status = fpa_pkg::ST_DIVZ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (en) begin
      tok <= t;
    end
  end

endmodule
`default_nettype wire

@@ design/fpa_div_cell.sv @@
`default_nettype none
module fpa_div_cell (
  input  wire            clk,
  input  wire            rst,
  input  wire            en,
  input  fpa_pkg::tok_t  tok_in,
  output fpa_pkg::tok_t  tok_out
);

  localparam int W = fpa_pkg::WORD_BITS;
  localparam int N = fpa_pkg::NUM_W;

  // One restoring step: bring down the next numerator bit and try the subtract.
  fpa_pkg::tok_t t;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    t     = tok_in;
    trial = {tok_in.rem, tok_in.num[N-1]};
    diff  = trial - {1'b0, tok_in.den};
    t.num = tok_in.num << 1;
    if (!diff[W]) begin
      t.rem = diff[W-1:0];
      t.quo = {tok_in.quo[N-2:0], 1'b1};
    end else begin
      t.rem = trial[W-1:0];
      t.quo = {tok_in.quo[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= t;
    end
  end

endmodule
`default_nettype wire

@@ design/fixed_point_q24_8_alu.sv @@
`default_nettype none
// Channel  Dir  tdata (low bit first)                              Handshake
// s_axis   in   opcode[3:0] operand_a[35:4] operand_b[67:36] pad   tvalid/tready
// m_axis   out  result_value[31:0] compare_true[32] status[34:33]  tvalid/tready
//
// Every request passes the same pipeline: one front stage, one restoring
// divider cell per quotient bit (41 cells), then the output register. These are
// 43 register stages. A new request is taken every cycle while the output is
// not stalled. A stall on the output freezes the whole pipeline. Reset clears
// all valid flags only.
module fixed_point_q24_8_alu (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,   // opcode, operand_a, operand_b, zero pad
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // result_value, compare_true, status, zero pad
);

  localparam int W = fpa_pkg::WORD_BITS;
  localparam int F = fpa_pkg::FRAC_BITS;
  localparam int N = fpa_pkg::NUM_W;
  localparam int S = fpa_pkg::SAT_W;

  logic          en;
  fpa_pkg::tok_t chain [0:N];

  logic signed [W-1:0] result_value;
  logic                compare_true;
  logic [1:0]          status;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .opcode    (s_axis_tdata[3:0]),
    .operand_a (s_axis_tdata[35:4]),
    .operand_b (s_axis_tdata[67:36]),
    .tok       (chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  fpa_pkg::tok_t       tl;
  fpa_pkg::sat_t       s;
  logic [2*W-1:0]      pmag;
  logic [2*W-1:0]      pround;
  logic [N:0]          q;
  logic signed [S-1:0] v;
  logic signed [W-1:0] res_next;
  logic [1:0]          status_next;

  always_comb begin
    tl          = chain[N];
    pmag        = tl.prod[2*W-1] ? (2*W)'(-tl.prod) : (2*W)'(tl.prod);
    pround      = (pmag + (2*W)'(1 << (F-1))) >> F;
    q           = ({1'b0, tl.quo} + (N+1)'(1)) >> 1;
    v           = '0;
    res_next    = tl.res;
    status_next = tl.status;
    if (tl.op == fpa_pkg::OP_MUL) begin
      v = tl.prod[2*W-1] ? -S'(pround) : S'(pround);
    end else begin
      v = tl.neg ? -S'(q) : S'(q);
    end
    s = fpa_pkg::saturate(v);
    if (tl.op == fpa_pkg::OP_MUL ||
        (tl.op == fpa_pkg::OP_DIV && tl.status != fpa_pkg::ST_DIVZ)) begin
      res_next    = s.val;
      status_next = s.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= tl.valid;
      result_value  <= res_next;
      compare_true  <= tl.cmp;
      status        <= status_next;
    end
  end

  assign m_axis_tdata = {5'b0, status, compare_true, result_value};

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status == fpa_pkg::ST_DIVZ |-> result_value == '0)
    else $error("divide by zero result not zero");
  a_cmp_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && compare_true |-> status == fpa_pkg::ST_OK && result_value == '0)
    else $error("comparison with nonzero result or status");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(result_value) && $stable(status))
    else $error("output changed while stalled");

endmodule
`default_nettype wire
